/* sv/assert_macros.svh */
// Assertion macros used by the RTL core of the fixed-point multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/sfpm_pkg.sv */
// Shared widths, codes and types of the saturating fixed-point multiplier.
`timescale 1ns / 1ps
package sfpm_pkg;
    localparam int WORD_W  = 32;
    localparam int PROD_W  = 64;
    localparam int POINT_W = 7;
    localparam int AMT_W   = 6;
    localparam int IDX_W   = 2;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    localparam logic [IDX_W-1:0] REG_B_POINT = 2'd0;
    localparam logic [IDX_W-1:0] REG_C_POINT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RESULT  = 2'd2;

    typedef struct packed {
        logic             left;
        logic             big;
        logic [AMT_W-1:0] amt;
    } shift_ctl_t;
endpackage

/* sv/sfpm_rescale.sv */
// Moves the 64-bit product magnitude to the result binary point with saturation.
`timescale 1ns / 1ps
module sfpm_rescale
(
    input  logic [sfpm_pkg::PROD_W-1:0] mag,
    input  sfpm_pkg::shift_ctl_t        ctl,
    output logic [sfpm_pkg::WORD_W-1:0] lng
);
    logic [sfpm_pkg::PROD_W-1:0] down;
    logic [sfpm_pkg::PROD_W-1:0] up;

    assign down = mag >> ctl.amt;
    assign up   = {{sfpm_pkg::WORD_W{1'b0}}, mag[sfpm_pkg::WORD_W-1:0]} << ctl.amt;

    always_comb
    begin
        if (!ctl.left)
        begin
            if (ctl.big)
                lng = '0;
            else if (down[sfpm_pkg::PROD_W-1:sfpm_pkg::WORD_W] != '0)
                lng = '1;
            else
                lng = down[sfpm_pkg::WORD_W-1:0];
        end
        else
        begin
            if (mag[sfpm_pkg::PROD_W-1:sfpm_pkg::WORD_W] != '0)
                lng = '1;
            else if (mag[sfpm_pkg::WORD_W-1:0] == '0)
                lng = '0;
            else if (ctl.big)
                lng = '1;
            else if (up[sfpm_pkg::PROD_W-1:sfpm_pkg::WORD_W] != '0)
                lng = '1;
            else
                lng = up[sfpm_pkg::WORD_W-1:0];
        end
    end
endmodule

/* sv/sat_fixed_point_mul32_core.sv */
// Top level of the saturating fixed-point 32-bit multiplier pipeline.
// The block accepts one item per clock cycle while in_ready is high, through a four-stage
// pipeline: sign and shift setup, a 32 by 32 multiply, the rescale shifter with saturation,
// and the signed clip into the output register. A stalled output holds the pipeline only where
// stages are full, so bubbles are squeezed out first. The user must write the binary point
// registers through the cfg port while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sat_fixed_point_mul32_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sfpm_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sfpm_pkg::POINT_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [sfpm_pkg::WORD_W-1:0]         operand_b,
    input  logic [sfpm_pkg::WORD_W-1:0]         operand_c,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfpm_pkg::WORD_W-1:0]         product
);
    logic [sfpm_pkg::POINT_W-1:0] b_point_reg;
    logic [sfpm_pkg::POINT_W-1:0] c_point_reg;
    logic [sfpm_pkg::POINT_W-1:0] r_point_reg;

    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    logic                         rdy1, rdy2, rdy3, rdy4;

    logic                         op1_reg, op2_reg, op3_reg, op4_reg;
    logic                         neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [sfpm_pkg::WORD_W-1:0]  b1_reg, c1_reg;
    sfpm_pkg::shift_ctl_t         ctl1_reg, ctl2_reg;
    logic [sfpm_pkg::PROD_W-1:0]  mag2_reg;
    logic [sfpm_pkg::WORD_W-1:0]  lng3_reg;
    logic [sfpm_pkg::WORD_W-1:0]  product_reg;

    logic                         neg_b, neg_c;
    logic [sfpm_pkg::WORD_W-1:0]  mag_b, mag_c;
    logic signed [8:0]            point_sum;
    logic signed [8:0]            shift_d;
    logic [8:0]                   shift_mag;
    sfpm_pkg::shift_ctl_t         ctl_next;
    logic [sfpm_pkg::WORD_W-1:0]  lng_next;
    logic [sfpm_pkg::WORD_W-1:0]  product_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v4_reg;
    assign product   = product_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_point_reg <= '0;
            c_point_reg <= '0;
            r_point_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfpm_pkg::REG_B_POINT: b_point_reg <= cfg_data;
                sfpm_pkg::REG_C_POINT: c_point_reg <= cfg_data;
                sfpm_pkg::REG_RESULT:  r_point_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        neg_b     = (opcode == sfpm_pkg::OP_SIGNED) && operand_b[sfpm_pkg::WORD_W-1];
        neg_c     = (opcode == sfpm_pkg::OP_SIGNED) && operand_c[sfpm_pkg::WORD_W-1];
        mag_b     = neg_b ? (~operand_b + 1'b1) : operand_b;
        mag_c     = neg_c ? (~operand_c + 1'b1) : operand_c;
        point_sum = 9'(signed'(b_point_reg)) + 9'(signed'(c_point_reg));
        shift_d   = 9'(signed'(r_point_reg)) - point_sum;
        shift_mag = shift_d[8] ? (~shift_d + 1'b1) : shift_d;
        ctl_next.left = !shift_d[8];
        ctl_next.big  = shift_d[8] ? (shift_mag >= 9'd64) : (shift_mag >= 9'd32);
        ctl_next.amt  = shift_mag[sfpm_pkg::AMT_W-1:0];
    end

    sfpm_rescale u_rescale
    (
        .mag (mag2_reg),
        .ctl (ctl2_reg),
        .lng (lng_next)
    );

    always_comb
    begin
        if (op3_reg == sfpm_pkg::OP_UNSIGNED)
            product_next = lng3_reg;
        else if (lng3_reg[sfpm_pkg::WORD_W-1])
            product_next = neg3_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            product_next = neg3_reg ? (~lng3_reg + 1'b1) : lng3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            op1_reg  <= opcode;
            neg1_reg <= neg_b ^ neg_c;
            b1_reg   <= mag_b;
            c1_reg   <= mag_c;
            ctl1_reg <= ctl_next;
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg  <= op1_reg;
            neg2_reg <= neg1_reg;
            mag2_reg <= {{sfpm_pkg::WORD_W{1'b0}}, b1_reg} * {{sfpm_pkg::WORD_W{1'b0}}, c1_reg};
            ctl2_reg <= ctl1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            op3_reg  <= op2_reg;
            neg3_reg <= neg2_reg;
            lng3_reg <= lng_next;
        end
        if (rdy4 && v3_reg)
        begin
            op4_reg     <= op3_reg;
            neg4_reg    <= neg3_reg;
            product_reg <= product_next;
        end
    end

    `ASSERT_SAME(a_unsigned_no_sign, clk, rst_n,
        v2_reg && (op2_reg == sfpm_pkg::OP_UNSIGNED), !neg2_reg,
        "unsigned item carries a negative sign")
    `ASSERT_SAME(a_pos_result, clk, rst_n,
        v4_reg && (op4_reg == sfpm_pkg::OP_SIGNED) && !neg4_reg,
        !product_reg[sfpm_pkg::WORD_W-1],
        "positive signed item gave a negative product")
    `ASSERT_SAME(a_neg_result, clk, rst_n,
        v4_reg && (op4_reg == sfpm_pkg::OP_SIGNED) && neg4_reg,
        product_reg[sfpm_pkg::WORD_W-1] || (product_reg == '0),
        "negative signed item gave a positive product")
    `ASSERT_NEXT(a_stage1_hold, clk, rst_n, v1_reg && !rdy2, v1_reg,
        "item lost in stage one under stall")
endmodule

/* sim/tb.sv */
// Self-checking testbench of the saturating fixed-point 32-bit multiplier core.
`timescale 1ns / 1ps
module tb;
    typedef struct {
        logic                        op;
        logic [sfpm_pkg::WORD_W-1:0] b;
        logic [sfpm_pkg::WORD_W-1:0] c;
        logic [sfpm_pkg::WORD_W-1:0] product;
    } product_exp_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [sfpm_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [sfpm_pkg::POINT_W-1:0] cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         opcode = sfpm_pkg::OP_UNSIGNED;
    logic [sfpm_pkg::WORD_W-1:0]  operand_b = '0;
    logic [sfpm_pkg::WORD_W-1:0]  operand_c = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [sfpm_pkg::WORD_W-1:0]  product;

    logic signed [sfpm_pkg::POINT_W-1:0] b_point_cfg = '0;
    logic signed [sfpm_pkg::POINT_W-1:0] c_point_cfg = '0;
    logic signed [sfpm_pkg::POINT_W-1:0] res_point_cfg = '0;

    product_exp_t expected_products[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_asked = 0;
    int           hold_taken = 0;
    int           hold_len = 0;
    int           mismatches = 0;
    int           items_sent = 0;
    int           results_checked = 0;
    int           point_settings = 0;

    sat_fixed_point_mul32_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .product   (product)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("** sat_fixed_point_mul32_core: FAILED **");
        $finish;
    end

    function automatic logic [sfpm_pkg::WORD_W-1:0] scaled_product(
        input logic                        op,
        input logic [sfpm_pkg::WORD_W-1:0] b,
        input logic [sfpm_pkg::WORD_W-1:0] c);
        logic                        neg;
        logic [sfpm_pkg::WORD_W-1:0] mag_b;
        logic [sfpm_pkg::WORD_W-1:0] mag_c;
        logic [sfpm_pkg::PROD_W-1:0] mag;
        logic [sfpm_pkg::PROD_W-1:0] wide;
        logic [sfpm_pkg::WORD_W-1:0] mag32;
        int                          shift;
        neg = 1'b0;
        mag_b = b;
        mag_c = c;
        if (op == sfpm_pkg::OP_SIGNED)
        begin
            if (b[sfpm_pkg::WORD_W-1])
            begin
                neg = ~neg;
                mag_b = -b;
            end
            if (c[sfpm_pkg::WORD_W-1])
            begin
                neg = ~neg;
                mag_c = -c;
            end
        end
        mag = {32'd0, mag_b} * {32'd0, mag_c};
        shift = int'(res_point_cfg) - (int'(b_point_cfg) + int'(c_point_cfg));
        if (shift < 0)
        begin
            if (-shift >= sfpm_pkg::PROD_W)
                mag32 = '0;
            else
            begin
                wide = mag >> (-shift);
                mag32 = (wide[sfpm_pkg::PROD_W-1:sfpm_pkg::WORD_W] != 0) ? '1 :
                        wide[sfpm_pkg::WORD_W-1:0];
            end
        end
        else if (mag[sfpm_pkg::PROD_W-1:sfpm_pkg::WORD_W] != 0)
            mag32 = '1;
        else if (mag[sfpm_pkg::WORD_W-1:0] == 0 || shift == 0)
            mag32 = mag[sfpm_pkg::WORD_W-1:0];
        else if (shift >= sfpm_pkg::WORD_W)
            mag32 = '1;
        else if ((mag[sfpm_pkg::WORD_W-1:0] >> (sfpm_pkg::WORD_W - shift)) != 0)
            mag32 = '1;
        else
            mag32 = mag[sfpm_pkg::WORD_W-1:0] << shift;
        if (op == sfpm_pkg::OP_UNSIGNED)
            return mag32;
        if (mag32[sfpm_pkg::WORD_W-1])
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return neg ? -mag32 : mag32;
    endfunction

    function automatic logic [sfpm_pkg::WORD_W-1:0] random_operand();
        unique case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(16'hFFFF);
            2: return -$urandom_range(16'hFFFF);
            3:
            begin
                unique case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_len <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_len > 0)
        begin
            out_ready <= 1'b0;
            hold_len <= hold_len - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_products
        product_exp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_products.size() == 0)
                report_mismatch($sformatf("product %h with no item outstanding", product));
            else
            begin
                want = expected_products.pop_front();
                results_checked++;
                if (product !== want.product)
                    report_mismatch($sformatf("op %0d b %h c %h: product %h, expected %h",
                                              want.op, want.b, want.c, product,
                                              want.product));
            end
        end
    end

    task automatic send_item(input logic op, input logic [sfpm_pkg::WORD_W-1:0] b,
                             input logic [sfpm_pkg::WORD_W-1:0] c);
        product_exp_t item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        operand_b <= b;
        operand_c <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        item.op = op;
        item.b = b;
        item.c = c;
        item.product = scaled_product(op, b, c);
        expected_products.push_back(item);
        items_sent++;
    endtask

    task automatic drain_products();
        in_valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_points(input logic signed [sfpm_pkg::POINT_W-1:0] b_pt,
                              input logic signed [sfpm_pkg::POINT_W-1:0] c_pt,
                              input logic signed [sfpm_pkg::POINT_W-1:0] r_pt);
        drain_products();
        cfg_we <= 1'b1;
        cfg_index <= sfpm_pkg::REG_B_POINT;
        cfg_data <= b_pt;
        @(posedge clk);
        cfg_index <= sfpm_pkg::REG_C_POINT;
        cfg_data <= c_pt;
        @(posedge clk);
        cfg_index <= sfpm_pkg::REG_RESULT;
        cfg_data <= r_pt;
        @(posedge clk);
        cfg_we <= 1'b0;
        b_point_cfg = b_pt;
        c_point_cfg = c_pt;
        res_point_cfg = r_pt;
        point_settings++;
    endtask

    task automatic test_directed_extremes();
        set_points(7'sd0, 7'sd0, 7'sd0);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0000_0000, 32'h0000_0000);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0000_FFFF, 32'h0001_0001);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0001_0000, 32'h0001_0000);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(sfpm_pkg::OP_SIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(sfpm_pkg::OP_SIGNED, 32'h8000_0000, 32'h8000_0000);
        send_item(sfpm_pkg::OP_SIGNED, 32'h8000_0000, 32'h0000_0001);
        send_item(sfpm_pkg::OP_SIGNED, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(sfpm_pkg::OP_SIGNED, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(sfpm_pkg::OP_SIGNED, 32'h0000_0000, 32'h8000_0000);
        send_item(sfpm_pkg::OP_SIGNED, 32'h0001_0000, 32'hFFFF_8000);
    endtask

    task automatic test_point_extremes();
        set_points(7'sd63, 7'sd63, -7'sd64);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(sfpm_pkg::OP_SIGNED, 32'h8000_0000, 32'h8000_0000);
        set_points(-7'sd64, -7'sd64, 7'sd63);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(sfpm_pkg::OP_SIGNED, 32'h0000_0001, 32'h0000_0001);
        send_item(sfpm_pkg::OP_SIGNED, 32'hFFFF_FFFF, 32'h0000_0001);
        set_points(7'sd0, 7'sd0, -7'sd64);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_points(7'sd0, 7'sd0, -7'sd63);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_points(7'sd0, 7'sd0, -7'sd32);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(sfpm_pkg::OP_SIGNED, 32'h8000_0000, 32'h8000_0000);
        set_points(7'sd0, 7'sd0, 7'sd31);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0000_0001, 32'h0000_0001);
        send_item(sfpm_pkg::OP_SIGNED, 32'h0000_0001, 32'h0000_0001);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0000_0003, 32'h0000_0001);
        set_points(7'sd0, 7'sd0, 7'sd32);
        send_item(sfpm_pkg::OP_UNSIGNED, 32'h0000_0001, 32'h0000_0001);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int settings, input int items);
        logic signed [sfpm_pkg::POINT_W-1:0] b_pt;
        logic signed [sfpm_pkg::POINT_W-1:0] c_pt;
        logic signed [sfpm_pkg::POINT_W-1:0] r_pt;
        logic [31:0]                         rnd;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (settings)
        begin
            if ($urandom_range(1))
            begin
                rnd = $urandom_range(127);
                b_pt = rnd[sfpm_pkg::POINT_W-1:0];
                rnd = $urandom_range(127);
                c_pt = rnd[sfpm_pkg::POINT_W-1:0];
                rnd = $urandom_range(127);
                r_pt = rnd[sfpm_pkg::POINT_W-1:0];
            end
            else
            begin
                rnd = $urandom_range(32) - 16;
                b_pt = rnd[sfpm_pkg::POINT_W-1:0];
                rnd = $urandom_range(32) - 16;
                c_pt = rnd[sfpm_pkg::POINT_W-1:0];
                rnd = $urandom_range(32) - 16;
                r_pt = rnd[sfpm_pkg::POINT_W-1:0];
            end
            set_points(b_pt, c_pt, r_pt);
            repeat (items)
                send_item(logic'($urandom_range(1)), random_operand(), random_operand());
        end
    endtask

    task automatic test_output_hold_off();
        set_points(7'sd8, 7'sd8, 7'sd16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        repeat (64)
            send_item(logic'($urandom_range(1)), random_operand(), random_operand());
        while (hold_taken != hold_asked || hold_len != 0)
            @(posedge clk);
    endtask

    task automatic test_pause_and_resume();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        repeat (20)
            send_item(logic'($urandom_range(1)), random_operand(), random_operand());
        drain_products();
        repeat (20)
            send_item(logic'($urandom_range(1)), random_operand(), random_operand());
    endtask

    initial
    begin
        int wait_cycles;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_point_extremes();
        test_random_traffic(22, 46, 5, 110);
        test_random_traffic(46, 22, 5, 110);
        test_random_traffic(0, 0, 5, 110);
        test_output_hold_off();
        test_pause_and_resume();
        in_valid <= 1'b0;
        recv_idle_pct = 0;
        wait_cycles = 0;
        while (expected_products.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_products.size() != 0)
            report_mismatch($sformatf("%0d products never arrived",
                                      expected_products.size()));
        $display("Sent %0d multiplies under %0d binary point settings, checked %0d products.",
                 items_sent, point_settings, results_checked);
        $display("Covered both opcodes, shift and saturation extremes, stalls and backpressure.");
        if (mismatches == 0)
            $display("** sat_fixed_point_mul32_core: PASSED **");
        else
            $display("** sat_fixed_point_mul32_core: FAILED **");
        $finish;
    end
endmodule
